FILE: design/kpd_pkg.sv
package kpd_pkg;

	// Event byte layout.
	localparam int unsigned EventWidth = 8;
	localparam int unsigned KeyWidth   = 7;
	localparam int unsigned CellWidth  = 6;

	// Only the 4x10 matrix is mapped: key numbers 1 through 40.
	localparam logic [KeyWidth-1:0] KeyFirst = 7'd1;
	localparam logic [KeyWidth-1:0] KeyLast  = 7'd40;

	// Cells with a special role.
	localparam logic [CellWidth-1:0] CellSymbol    = 6'h1E;
	localparam logic [CellWidth-1:0] CellCaps      = 6'h1C;
	localparam logic [CellWidth-1:0] CellAlt       = 6'h14;
	localparam logic [CellWidth-1:0] CellBackspace = 6'h1D;
	localparam logic [CellWidth-1:0] CellAltB      = 6'h19;

	// Character codes.
	localparam logic [7:0] ChNull      = 8'd0;
	localparam logic [7:0] ChBackspace = 8'd8;
	localparam logic [7:0] ChSpace     = 8'd32;
	localparam logic [7:0] ChLowerA    = 8'd97;
	localparam logic [7:0] ChLowerZ    = 8'd122;
	localparam logic [7:0] CaseOffset  = 8'd32;

	// Result of translating one event.
	typedef struct packed {
		logic       emit;
		logic [7:0] char_code;
	} xlate_res_t;

	// Base layer of the matrix.
	function automatic logic [7:0] base_char(input logic [CellWidth-1:0] cell_idx);
		logic [7:0] ch;
		unique case (cell_idx)
			6'd0:  ch = "q";
			6'd1:  ch = "w";
			6'd2:  ch = "e";
			6'd3:  ch = "r";
			6'd4:  ch = "t";
			6'd5:  ch = "y";
			6'd6:  ch = "u";
			6'd7:  ch = "i";
			6'd8:  ch = "o";
			6'd9:  ch = "p";
			6'd10: ch = "a";
			6'd11: ch = "s";
			6'd12: ch = "d";
			6'd13: ch = "f";
			6'd14: ch = "g";
			6'd15: ch = "h";
			6'd16: ch = "j";
			6'd17: ch = "k";
			6'd18: ch = "l";
			6'd19: ch = 8'd10;
			6'd21: ch = "z";
			6'd22: ch = "x";
			6'd23: ch = "c";
			6'd24: ch = "v";
			6'd25: ch = "b";
			6'd26: ch = "n";
			6'd27: ch = "m";
			6'd30: ch = " ";
			default: ch = ChNull;
		endcase
		return ch;
	endfunction

	// Symbol layer of the matrix.
	function automatic logic [7:0] sym_char(input logic [CellWidth-1:0] cell_idx);
		logic [7:0] ch;
		unique case (cell_idx)
			6'd0:  ch = "1";
			6'd1:  ch = "2";
			6'd2:  ch = "3";
			6'd3:  ch = "4";
			6'd4:  ch = "5";
			6'd5:  ch = "6";
			6'd6:  ch = "7";
			6'd7:  ch = "8";
			6'd8:  ch = "9";
			6'd9:  ch = "0";
			6'd10: ch = "*";
			6'd11: ch = "/";
			6'd12: ch = "+";
			6'd13: ch = "-";
			6'd14: ch = "=";
			6'd15: ch = ":";
			6'd16: ch = 8'd39;
			6'd17: ch = 8'd34;
			6'd18: ch = "@";
			6'd19: ch = 8'd27;
			6'd21: ch = "_";
			6'd22: ch = "$";
			6'd23: ch = ";";
			6'd24: ch = "?";
			6'd25: ch = "!";
			6'd26: ch = ",";
			6'd27: ch = ".";
			6'd30: ch = " ";
			default: ch = ChNull;
		endcase
		return ch;
	endfunction

endpackage

FILE: design/keypad_event_to_char.sv
// Keypad event translator: one event byte in, at most one ASCII character out.
// Path: an event passes the input register, then the lookup into the output
// register. Throughput: one event per cycle unless a result waits on a stalled
// output; the lookup is a single table stage.
// Reset (arst_n low, asynchronous) clears the modifier flags, the last
// character and both valid flags.
module keypad_event_to_char (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] raw_event,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_code
);

	logic                valid_s1;
	logic [7:0]          event_s1;
	logic                out_valid_q;
	logic [7:0]          char_q;
	logic                out_free;
	logic                s1_move;
	logic                in_take;
	kpd_pkg::xlate_res_t res;

	// Stage 1 leaves when it has no result or the output register can take one.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_move  = valid_s1 && (!res.emit || out_free);
	assign in_stall = valid_s1 && !s1_move;
	assign in_take  = in_valid && !in_stall;

	kpd_xlate u_xlate (
		.clk        (clk),
		.arst_n     (arst_n),
		.event_byte (event_s1),
		.fire       (s1_move),
		.res        (res)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || s1_move) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			event_s1 <= raw_event;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_move && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_move && res.emit) begin
			char_q <= res.char_code;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;

`ifndef SYNTHESIS
	// An empty input stage always takes a transfer.
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("empty input stage stalled");

	// A held event stays in the input stage.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |=> valid_s1 && $stable(event_s1))
		else $error("held event lost");

	// A pending character with a full, stalled output blocks new events.
	a_block_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.emit && out_valid_q && out_stall |-> in_stall)
		else $error("result overwritten while output stalled");
`endif

endmodule

FILE: design/kpd_xlate.sv
module kpd_xlate (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                event_byte,
	input  logic                      fire,
	output kpd_pkg::xlate_res_t       res
);

	logic       symbol_q;
	logic       caps_q;
	logic       alt_q;
	logic [7:0] prev_q;

	logic                                 press;
	logic [kpd_pkg::KeyWidth-1:0]         key;
	logic [kpd_pkg::KeyWidth-1:0]         key_m1;
	logic [kpd_pkg::CellWidth-1:0]        cell_idx;
	logic                                 key_ok;
	logic                                 symbol_d;
	logic                                 caps_d;
	logic                                 alt_d;
	logic [7:0]                           prev_d;
	logic [7:0]                           ch_lookup;
	logic [7:0]                           ch_cased;
	logic [7:0]                           ch_final;
	logic                                 press_final;

	// Split the event byte; only keys of the 4x10 matrix are taken.
	assign press    = event_byte[7];
	assign key      = event_byte[kpd_pkg::KeyWidth-1:0];
	assign key_m1   = key - 7'd1;
	assign cell_idx = key_m1[kpd_pkg::CellWidth-1:0];
	assign key_ok   = (key >= kpd_pkg::KeyFirst) && (key <= kpd_pkg::KeyLast);

	// Table lookup in the layer chosen after any symbol toggle.
	always_comb begin
		symbol_d = symbol_q;
		if (key_ok && cell_idx == kpd_pkg::CellSymbol) begin
			symbol_d = !symbol_q;
		end
		ch_lookup = symbol_d ? kpd_pkg::sym_char(cell_idx) : kpd_pkg::base_char(cell_idx);
		ch_cased  = ch_lookup;
		if (!symbol_d && caps_q && ch_lookup >= kpd_pkg::ChLowerA &&
				ch_lookup <= kpd_pkg::ChLowerZ) begin
			ch_cased = ch_lookup - kpd_pkg::CaseOffset;
		end
		ch_final    = ch_cased;
		press_final = press;
		if (symbol_d && ch_cased == kpd_pkg::ChSpace) begin
			ch_final = kpd_pkg::ChNull;
		end else if (!symbol_d && prev_q == kpd_pkg::ChNull) begin
			ch_final    = kpd_pkg::ChSpace;
			press_final = 1'b1;
		end
	end

	// Decide the result and the next modifier state for this event.
	always_comb begin
		caps_d        = caps_q;
		alt_d         = alt_q;
		prev_d        = prev_q;
		res.emit      = 1'b0;
		res.char_code = ch_final;
		if (key_ok) begin
			if (cell_idx == kpd_pkg::CellCaps) begin
				caps_d = !caps_q;
			end else if (cell_idx == kpd_pkg::CellAlt) begin
				alt_d = !alt_q;
			end else if (cell_idx == kpd_pkg::CellBackspace) begin
				res.emit      = press;
				res.char_code = kpd_pkg::ChBackspace;
			end else if (alt_q && cell_idx == kpd_pkg::CellAltB) begin
				res.emit = 1'b0;
			end else begin
				prev_d   = ch_final;
				res.emit = press_final && (ch_final != kpd_pkg::ChNull);
			end
		end
	end

	// Modifier flags and last character advance once per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_q <= 1'b0;
			caps_q   <= 1'b0;
			alt_q    <= 1'b0;
			prev_q   <= kpd_pkg::ChNull;
		end else if (fire) begin
			symbol_q <= symbol_d;
			caps_q   <= caps_d;
			alt_q    <= alt_d;
			prev_q   <= prev_d;
		end
	end

`ifndef SYNTHESIS
	// Backspace never disturbs the last character.
	a_bksp_keeps_prev: assert property (@(posedge clk) disable iff (!arst_n)
		fire && key_ok && cell_idx == kpd_pkg::CellBackspace |=> $stable(prev_q))
		else $error("backspace changed the last character");

	// An emitted result is never the null character.
	a_emit_nonnull: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |-> res.char_code != kpd_pkg::ChNull)
		else $error("null character emitted");

	// Without a transfer no flag may move.
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(symbol_q) && $stable(caps_q) && $stable(alt_q) && $stable(prev_q))
		else $error("state changed without a transfer");
`endif

endmodule
